// ===== rtl/h3cs_pkg.sv =====
// Shared types and constants for the H3 hash column select block.
package h3cs_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int KEY_BITS    = 64;
    localparam int TABLE_DEPTH = MAX_ROWS + KEY_BITS - 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int COL_W    = 32;
    localparam int ROWCFG_W = 5;
    localparam int ROW_W    = 4;
    localparam int WIDX_W   = 7;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_HASH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_HASH    = 2'd0,
        ST_LOAD    = 2'd1,
        ST_BAD_ROW = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd1;

    typedef struct packed {
        logic                command;
        logic [WIDX_W-1:0]   word_index;
        logic [63:0]         seed_word;
        logic [KEY_BITS-1:0] key_value;
        logic [ROW_W-1:0]    row_index;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [1:0]       status;
    } out_item_t;

    // requests into the fold unit
    typedef struct packed {
        logic                start;
        logic                load;
        logic [WIDX_W-1:0]   word_index;
        logic [63:0]         seed_word;
        logic [KEY_BITS-1:0] key;
        logic [ROW_W-1:0]    row;
    } fold_req_t;

    // requests into the remainder unit
    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] dividend;
        logic [COL_W-1:0]    divisor;
    } mod_req_t;

endpackage

// ===== rtl/h3cs_fold_unit.sv =====
// Seed table and bit-serial XOR fold over a row's seed window.
module h3cs_fold_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  h3cs_pkg::fold_req_t        req,
    output logic                       done,
    output logic [h3cs_pkg::KEY_BITS-1:0] hash
);
    import h3cs_pkg::*;

    localparam int CNT_W = $clog2(KEY_BITS + 1);
    localparam int BIT_W = $clog2(KEY_BITS);

    logic [63:0]         mem [TABLE_DEPTH];
    logic                issue_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                rd_valid_reg;
    logic                done_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [63:0]         rd_data_reg;
    logic                rd_bit_reg;
    logic                rd_last_reg;
    logic [63:0]         acc_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    logic                last_issue;

    assign rd_addr    = ADDR_W'(row_reg) + ADDR_W'(cnt_reg[BIT_W-1:0]);
    assign wr_addr    = ADDR_W'(req.word_index);
    assign wr_en      = req.load && (32'(req.word_index) < TABLE_DEPTH);
    assign last_issue = (cnt_reg == CNT_W'(KEY_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.seed_word;
        end
        if (issue_reg)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                issue_reg <= 1'b1;
                cnt_reg   <= '0;
            end
            else if (issue_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_issue)
                begin
                    issue_reg <= 1'b0;
                end
            end
            rd_valid_reg <= issue_reg;
            done_reg     <= rd_valid_reg && rd_last_reg;
        end
    end

    // key bit b lines up with the read of window word b
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            key_reg <= req.key;
            row_reg <= req.row;
            acc_reg <= '0;
        end
        else
        begin
            if (issue_reg)
            begin
                key_reg <= key_reg >> 1;
            end
            if (rd_valid_reg && rd_bit_reg)
            begin
                acc_reg <= acc_reg ^ rd_data_reg;
            end
        end
        rd_bit_reg  <= key_reg[0];
        rd_last_reg <= issue_reg && last_issue;
    end

    assign done = done_reg;
    assign hash = acc_reg;

endmodule

// ===== rtl/h3cs_mod_unit.sv =====
// Restoring remainder unit: 64-bit dividend by 32-bit divisor, one bit per cycle.
module h3cs_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  h3cs_pkg::mod_req_t         req,
    output logic                       done,
    output logic [h3cs_pkg::COL_W-1:0] remainder
);
    import h3cs_pkg::*;

    localparam int CNT_W = $clog2(KEY_BITS);

    logic                run_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [COL_W-1:0]    rem_reg;
    logic [KEY_BITS-1:0] dvd_reg;
    logic [COL_W-1:0]    dsr_reg;
    logic [COL_W:0]      shifted;
    logic [COL_W+1:0]    diff;
    logic [COL_W-1:0]    rem_next;

    assign shifted  = {rem_reg, dvd_reg[KEY_BITS-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dsr_reg};
    assign rem_next = diff[COL_W+1] ? shifted[COL_W-1:0] : diff[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(KEY_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");
`endif

endmodule

// ===== rtl/h3_hash_column_select_core.sv =====
// Top level of the H3 hash column select block: command decode, config and sequencer.
//
// Usage:
//   Command channel: item is transferred at a rising edge with start high and
//   busy low. A load writes one seed word; a hash folds the key over the
//   64-word seed window of its row and reduces the result modulo cols_in_use.
//   Result: done is high for exactly one cycle with result valid in that
//   cycle; the receiver cannot stall, so every result must be taken then.
//   Sequencing: a load or an out-of-range row answers in the cycle after
//   transfer and busy stays low. A hash holds busy through 64 serial
//   seed-table reads with the XOR fold (one table read port, one word a
//   cycle) followed by 64 steps of the restoring remainder unit; the
//   result strobe comes in the first cycle with busy low. With cols_in_use
//   of zero the remainder pass is skipped and column 0 is given.
//   Config channel: cfg_valid/cfg_ready transfer cfg_data into the register
//   at cfg_index (0 cols_in_use, 1 rows_in_use); other indexes are ignored.
//   Write it only while no item is in flight.
//   Reset: asynchronous, active low; cols_in_use and rows_in_use return to 1.
//   Seed words hold no value until loaded.
module h3_hash_column_select_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  h3cs_pkg::in_item_t             item,
    output logic                           done,
    output h3cs_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [h3cs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import h3cs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD,
        S_MOD
    } state_t;

    state_t               state_reg;
    logic                 done_reg;
    out_item_t            result_reg;
    logic [COL_W-1:0]     cols_reg;
    logic [ROWCFG_W-1:0]  rows_reg;
    logic                 accept;
    logic                 is_hash;
    logic                 row_bad;
    fold_req_t            fold_req;
    mod_req_t             mod_req;
    logic                 fold_done;
    logic [KEY_BITS-1:0]  fold_hash;
    logic                 mod_done;
    logic [COL_W-1:0]     mod_rem;

    assign accept  = start && (state_reg == S_IDLE);
    assign is_hash = (item.command == CMD_HASH);
    assign row_bad = ({1'b0, item.row_index} >= rows_reg)
                     || (32'(item.row_index) >= MAX_ROWS);

    always_comb
    begin
        fold_req            = '0;
        fold_req.start      = accept && is_hash && !row_bad;
        fold_req.load       = accept && !is_hash;
        fold_req.word_index = item.word_index;
        fold_req.seed_word  = item.seed_word;
        fold_req.key        = item.key_value;
        fold_req.row        = item.row_index;
    end

    always_comb
    begin
        mod_req          = '0;
        mod_req.start    = (state_reg == S_FOLD) && fold_done && (cols_reg != '0);
        mod_req.dividend = fold_hash;
        mod_req.divisor  = cols_reg;
    end

    h3cs_fold_unit u_fold (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fold_req),
        .done  (fold_done),
        .hash  (fold_hash)
    );

    h3cs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!is_hash)
                        begin
                            done_reg          <= 1'b1;
                            result_reg.column <= '0;
                            result_reg.status <= ST_LOAD;
                        end
                        else if (row_bad)
                        begin
                            done_reg          <= 1'b1;
                            result_reg.column <= '0;
                            result_reg.status <= ST_BAD_ROW;
                        end
                        else
                        begin
                            state_reg <= S_FOLD;
                        end
                    end
                end
                S_FOLD:
                begin
                    if (fold_done)
                    begin
                        if (cols_reg == '0)
                        begin
                            // zero column count: column 0, plain hash status
                            done_reg          <= 1'b1;
                            result_reg.column <= '0;
                            result_reg.status <= ST_HASH;
                            state_reg         <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        done_reg          <= 1'b1;
                        result_reg.column <= mod_rem;
                        result_reg.status <= ST_HASH;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COL_W'(1);
            rows_reg <= ROWCFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLS_IN_USE: cols_reg <= cfg_data[COL_W-1:0];
                CFG_ROWS_IN_USE: rows_reg <= cfg_data[ROWCFG_W-1:0];
                default:         ;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.status == ST_HASH || result_reg.status == ST_LOAD
                      || result_reg.status == ST_BAD_ROW))
        else $error("illegal result status");

    a_zero_column: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status != ST_HASH) |-> (result_reg.column == '0))
        else $error("non-zero column on load or bad row");

    a_mod_only_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_MOD))
        else $error("remainder finished outside its phase");
`endif

endmodule

// ===== tb/h3_hash_column_select_checker.sv =====
// Checker for the H3 column select core: mirrors seed table and config, predicts and compares results.
`timescale 1ns / 100ps
module h3_hash_column_select_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  h3cs_pkg::in_item_t             item,
    input  logic                           done,
    input  h3cs_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [h3cs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import h3cs_pkg::*;

    logic [63:0]         seed_mirror [TABLE_DEPTH];
    logic [COL_W-1:0]    cols_reg;
    logic [ROWCFG_W-1:0] rows_reg;
    out_item_t           column_queue [$];
    out_item_t           want;
    int                  errs;
    int                  w;

    function automatic logic [63:0] window_fold(logic [63:0] key, logic [ROW_W-1:0] row);
        logic [63:0] acc;
        int          b;
        acc = '0;
        for (b = 0; b < KEY_BITS; b++)
            if (key[b] && (int'(row) + b) < TABLE_DEPTH)
                acc ^= seed_mirror[int'(row) + b];
        return acc;
    endfunction

    // loads update the mirror here, so call once per accepted command
    function automatic out_item_t predict_column_result(in_item_t it);
        out_item_t   r;
        logic [63:0] h;
        r.column = '0;
        if (it.command == CMD_LOAD)
        begin
            if (it.word_index < TABLE_DEPTH)
                seed_mirror[it.word_index] = it.seed_word;
            r.status = ST_LOAD;
        end
        else if (it.row_index >= rows_reg || it.row_index >= MAX_ROWS)
        begin
            r.status = ST_BAD_ROW;
        end
        else
        begin
            h = window_fold(it.key_value, it.row_index);
            if (cols_reg != 0)
                r.column = COL_W'(h % {32'd0, cols_reg});
            r.status = ST_HASH;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (w = 0; w < TABLE_DEPTH; w++)
                seed_mirror[w] = '0;
            cols_reg = COL_W'(1);
            rows_reg = ROWCFG_W'(1);
            column_queue.delete();
            errs = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COLS_IN_USE: cols_reg = cfg_data;
                    CFG_ROWS_IN_USE: rows_reg = cfg_data[ROWCFG_W-1:0];
                    default: ;
                endcase
            end
            // a result at this edge always belongs to an earlier transfer
            if (done)
            begin
                if (column_queue.size() == 0)
                begin
                    $error("unexpected result: column %0d status %0d",
                           result.column, result.status);
                    errs++;
                end
                else
                begin
                    want = column_queue.pop_front();
                    if (result.column !== want.column)
                    begin
                        $error("column: expected %0d, got %0d", want.column, result.column);
                        errs++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                column_queue.push_back(predict_column_result(item));
            fail_count  <= errs;
            outstanding <= column_queue.size();
        end
    end

endmodule

// ===== tb/h3_hash_column_select_core_tb.sv =====
// Testbench top for the H3 hash column select core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module h3_hash_column_select_core_tb;
    import h3cs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          RAND_PHASES  = 9;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          HASH_LATENCY = 140;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_item_t             item;
    logic                 done;
    out_item_t            result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   fail_count;
    int                   outstanding;

    int                   idle_pct;
    logic [ROWCFG_W-1:0]  rows_now;
    int                   ph;
    int                   n;
    int                   wait_cnt;

    h3_hash_column_select_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    h3_hash_column_select_checker column_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[h3_hash_column_select_core] ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t load_item(logic [WIDX_W-1:0] idx, logic [63:0] seed);
        in_item_t it;
        it.command    = CMD_LOAD;
        it.word_index = idx;
        it.seed_word  = seed;
        it.key_value  = rand64();
        it.row_index  = ROW_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t hash_item(logic [63:0] key, logic [ROW_W-1:0] row);
        in_item_t it;
        it.command    = CMD_HASH;
        it.word_index = WIDX_W'($urandom);
        it.seed_word  = rand64();
        it.key_value  = key;
        it.row_index  = row;
        return it;
    endfunction

    // mostly in-range hashes over a fully loaded table, some reloads and noise
    function automatic in_item_t random_item(logic [ROWCFG_W-1:0] rows_cfg);
        int               sel;
        int               lim;
        logic [63:0]      key;
        logic [ROW_W-1:0] row;
        sel = $urandom_range(99);
        if (sel < 40)
            return load_item(WIDX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand64());
        if (sel < 45)
            return load_item(WIDX_W'($urandom_range(TABLE_DEPTH, 127)), rand64());
        case ($urandom_range(9))
            0:       key = 64'd1 << $urandom_range(63);
            1:       key = $urandom_range(1) ? ALL_ONES : 64'd0;
            2:       key = rand64() & rand64();
            default: key = rand64();
        endcase
        lim = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        if (lim == 0 || $urandom_range(9) == 0)
            row = ROW_W'($urandom_range(15));
        else
            row = ROW_W'($urandom_range(lim - 1));
        return hash_item(key, row);
    endfunction

    function automatic logic [31:0] pick_cols();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'($urandom_range(2, 16));
            4:       return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ROWCFG_W-1:0] pick_rows();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ROWCFG_W'($urandom_range(17, 31));
            2, 3:    return ROWCFG_W'(MAX_ROWS);
            default: return ROWCFG_W'($urandom_range(1, MAX_ROWS));
        endcase
    endfunction

    // start stays high after a transfer until the next item or an idle cycle
    task automatic send_item(in_item_t it);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic configure(logic [31:0] cols, logic [ROWCFG_W-1:0] rows);
        logic [31:0] rows_word;
        settle();
        // upper bits of the row count are don't-care
        rows_word = {($urandom_range(3) == 0) ? 27'($urandom) : 27'd0, rows};
        write_reg(CFG_COLS_IN_USE, cols);
        write_reg(CFG_ROWS_IN_USE, rows_word);
        rows_now = rows;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_pct  = 0;
        rows_now  = ROWCFG_W'(1);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // whole table loaded before any hash reads it
        for (n = 0; n < TABLE_DEPTH; n++)
            send_item(load_item(WIDX_W'(n), (n == 0) ? ALL_ONES : rand64()));

        // directed: reset config, ignored loads, extreme keys and rows
        send_item(hash_item(ALL_ONES, 4'd0));
        send_item(hash_item(rand64(), 4'd1));
        send_item(load_item(7'd79, ALL_ONES));
        send_item(load_item(7'd127, rand64()));
        configure(32'hFFFF_FFFF, 5'd16);
        send_item(hash_item(64'd0, 4'd0));
        send_item(hash_item(ALL_ONES, 4'd15));
        send_item(hash_item(64'd1, 4'd0));
        send_item(hash_item(64'd1 << 63, 4'd15));
        send_item(hash_item(rand64(), 4'd8));
        send_item(load_item(7'd78, ALL_ONES));
        send_item(hash_item(64'd1 << 63, 4'd15));
        // zero column count
        configure(32'd0, 5'd16);
        send_item(hash_item(rand64(), 4'd3));
        send_item(hash_item(ALL_ONES, 4'd15));
        // zero row count flags every row
        configure(32'd2, 5'd0);
        send_item(hash_item(rand64(), 4'd0));
        send_item(hash_item(rand64(), 4'd15));
        configure(32'd3, 5'd31);
        send_item(hash_item(rand64(), 4'd15));
        send_item(hash_item(rand64(), 4'd0));
        settle();
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        send_item(hash_item(rand64(), 4'd2));

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_pct = (ph < 3) ? 27 : ((ph < 6) ? 51 : 0);
            configure(pick_cols(), pick_rows());
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(rows_now));
        end

        @(negedge clk);
        start <= 1'b0;
        wait_cnt = 0;
        while ((outstanding != 0 || busy) && wait_cnt < 4 * HASH_LATENCY)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (HASH_LATENCY) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[h3_hash_column_select_core] OK");
        else
            $display("[h3_hash_column_select_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/h3cs_pkg.sv
rtl/h3cs_fold_unit.sv
rtl/h3cs_mod_unit.sv
rtl/h3_hash_column_select_core.sv
tb/h3_hash_column_select_checker.sv
tb/h3_hash_column_select_core_tb.sv
